>>> src/esf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esf_pkg
// Shared constants for the eigenvalue shape feature pipeline.
// ----------------------------------------------------------------------------
package esf_pkg;

    localparam int LAMBDA_W  = 32;                 // eigenvalue width
    localparam int LOG_FRAC  = 24;                 // log2 fraction bits
    localparam int MSB_W     = 5;                  // msb position width
    localparam int LOG_W     = MSB_W + LOG_FRAC;   // log2 value width
    localparam int LNMAG_W   = 30;                 // |ln| magnitude width
    localparam int TERM_W    = 48;                 // signed lambda*ln term
    localparam int ESUM_W    = 50;                 // signed term sum
    localparam int ENT_W     = 41;                 // entropy output width
    localparam int REM_W     = 35;                 // divider remainder width
    localparam int SUM_W     = 34;                 // sum of three eigenvalues
    localparam int USER_W    = 3;                  // flag bits in tuser

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic signed [ESUM_W-1:0] ENT_MAX = ESUM_W'(64'sd1099511627775);
    localparam logic signed [ESUM_W-1:0] ENT_MIN = -ESUM_W'(64'sd1099511627776);

    // tuser bit positions
    localparam int USER_DEGEN = 0;
    localparam int USER_ORDER = 1;
    localparam int USER_CURV  = 2;

endpackage

>>> src/eigenvalue_shape_features_core.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while m_axis is not stalled; each of
// the 24 log2 squaring stages holds one 32x32 multiplier per eigenvalue, and
// the first RATIO_FRAC_BITS of them one divider step per ratio. Stalls ripple
// back stage by stage, so a stalled output still lets the pipeline fill.
// Reset (aresetn low, synchronous) empties every stage and loads max_curvature
// with round(0.08 * 2^RATIO_FRAC_BITS).
// ----------------------------------------------------------------------------
// eigenvalue_shape_features_core
// Ratio, entropy and flag features from three covariance eigenvalues.
// ----------------------------------------------------------------------------
module eigenvalue_shape_features_core #(
    parameter int EIGEN_FRAC_BITS = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration: max_curvature
    input  logic                    cfg_wr_en,
    input  logic [RATIO_FRAC_BITS:0] cfg_wr_data,
    // input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: lambda_largest, lambda_middle, lambda_smallest
    input  logic [3*esf_pkg::LAMBDA_W-1:0] s_axis_tdata,
    // output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: scatter_ratio, linearity_ratio, planarity_ratio, curvature_ratio,
    //        entropy_value, zero padding
    output logic [((4*(RATIO_FRAC_BITS+1)+esf_pkg::ENT_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: degenerate_flag, order_error_flag, curvature_exceeds_flag
    output logic [esf_pkg::USER_W-1:0] m_axis_tuser
);

    localparam int RW       = RATIO_FRAC_BITS + 1;
    localparam int DATA_W   = 4*RW + esf_pkg::ENT_W;
    localparam int TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int NP       = esf_pkg::LOG_FRAC + 3;   // pipe stages before output
    localparam int LW       = esf_pkg::LAMBDA_W;
    localparam logic [RATIO_FRAC_BITS:0] RATIO_ONE = RW'(1) << RATIO_FRAC_BITS;
    localparam logic [RATIO_FRAC_BITS:0] CURV_RESET =
        RW'(((64'd8 << RATIO_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [esf_pkg::LOG_W-1:0] LOG_BASE =
        esf_pkg::LOG_W'(EIGEN_FRAC_BITS) << esf_pkg::LOG_FRAC;
    localparam logic [62:0] T_RND = 63'(1) << (EIGEN_FRAC_BITS + 7);

    typedef struct packed {
        logic [2:0][LW-1:0]                    lam;
        logic [2:0][LW-1:0]                    mant;
        logic [2:0][esf_pkg::LOG_FRAC-1:0]     frac;
        logic [2:0][esf_pkg::MSB_W-1:0]        msb;
        logic [2:0]                            zero;
        logic [3:0][esf_pkg::REM_W-1:0]        rem;
        logic [3:0][RATIO_FRAC_BITS-1:0]       quo;
        logic [3:0]                            clamp;
        logic [LW-1:0]                         den_a;
        logic [esf_pkg::SUM_W-1:0]             den_s;
        logic                                  degen;
        logic                                  order;
        logic [3:0][RATIO_FRAC_BITS:0]         ratio;
        logic [2:0][esf_pkg::LNMAG_W-1:0]      lnmag;
        logic [2:0]                            neg;
        logic [2:0][esf_pkg::TERM_W-1:0]       term;
    } pipe_t;

    pipe_t      pipe_reg  [NP];
    pipe_t      pipe_next [NP];
    logic [NP-1:0] valid_reg;
    logic [NP:0]   en;

    logic [RATIO_FRAC_BITS:0]       max_curv_reg;
    logic                           out_valid_reg;
    logic [TDATA_W-1:0]             out_data_reg, out_data_next;
    logic [esf_pkg::USER_W-1:0]     out_user_reg, out_user_next;

    // ready ripples back: a stage takes new data when empty or moving on
    assign en[NP] = !out_valid_reg || m_axis_tready;
    for (genvar i = 0; i < NP; i++) begin : g_en
        assign en[i] = !valid_reg[i] || en[i+1];
    end
    assign s_axis_tready = en[0];

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_curv_reg <= CURV_RESET;
        end else if (cfg_wr_en) begin
            max_curv_reg <= cfg_wr_data;
        end
    end

    // stage 0: msb search, mantissa normalise, divider set-up
    always_comb begin
        logic [LW-1:0]             a, b, c, v;
        logic [esf_pkg::MSB_W-1:0] k;
        logic [3:0][esf_pkg::REM_W-1:0] num, den;
        pipe_next[0] = '0;
        a = s_axis_tdata[LW-1:0];
        b = s_axis_tdata[2*LW-1:LW];
        c = s_axis_tdata[3*LW-1:2*LW];
        pipe_next[0].lam[0] = a;
        pipe_next[0].lam[1] = b;
        pipe_next[0].lam[2] = c;
        for (int n = 0; n < 3; n++) begin
            v = pipe_next[0].lam[n];
            k = '0;
            for (int i = 0; i < LW; i++) begin
                if (v[i]) k = esf_pkg::MSB_W'(i);
            end
            pipe_next[0].msb[n]  = k;
            pipe_next[0].mant[n] = v << (esf_pkg::MSB_W'(LW-1) - k);
            pipe_next[0].zero[n] = (v == '0);
        end
        pipe_next[0].den_a = a;
        pipe_next[0].den_s = esf_pkg::SUM_W'(a) + esf_pkg::SUM_W'(b) + esf_pkg::SUM_W'(c);
        pipe_next[0].degen = (a == '0);
        pipe_next[0].order = (a < b) || (b < c);
        num[0] = esf_pkg::REM_W'(c);
        num[1] = (a > b) ? esf_pkg::REM_W'(a - b) : '0;
        num[2] = (b > c) ? esf_pkg::REM_W'(b - c) : '0;
        num[3] = esf_pkg::REM_W'(c);
        den[0] = esf_pkg::REM_W'(a);
        den[1] = esf_pkg::REM_W'(a);
        den[2] = esf_pkg::REM_W'(a);
        den[3] = esf_pkg::REM_W'(pipe_next[0].den_s);
        for (int d = 0; d < 4; d++) begin
            // quotient reaches one: clamp and drop the division
            pipe_next[0].clamp[d] = (num[d] >= den[d]);
            pipe_next[0].rem[d]   = pipe_next[0].clamp[d] ? '0 : num[d];
        end
    end

    // stages 1..24: one squaring per log2 fraction bit, one divider step in the first RATIO_FRAC_BITS
    for (genvar j = 0; j < esf_pkg::LOG_FRAC; j++) begin : g_iter
        always_comb begin
            logic [63:0]               sq;
            logic [32:0]               sh;
            logic [esf_pkg::REM_W-1:0] r2, dv;
            logic                      qb;
            pipe_next[j+1] = pipe_reg[j];
            for (int n = 0; n < 3; n++) begin
                sq = 64'(pipe_reg[j].mant[n]) * 64'(pipe_reg[j].mant[n]);
                sh = sq[63:31];
                pipe_next[j+1].frac[n] = {pipe_reg[j].frac[n][esf_pkg::LOG_FRAC-2:0], sh[32]};
                pipe_next[j+1].mant[n] = sh[32] ? sh[32:1] : sh[31:0];
            end
            if (j < RATIO_FRAC_BITS) begin
                for (int d = 0; d < 4; d++) begin
                    dv = (d == 3) ? esf_pkg::REM_W'(pipe_reg[j].den_s)
                                  : esf_pkg::REM_W'(pipe_reg[j].den_a);
                    r2 = {pipe_reg[j].rem[d][esf_pkg::REM_W-2:0], 1'b0};
                    qb = (r2 >= dv);
                    pipe_next[j+1].rem[d] = qb ? r2 - dv : r2;
                    pipe_next[j+1].quo[d] =
                        {pipe_reg[j].quo[d][RATIO_FRAC_BITS-2:0], qb};
                end
            end
        end
    end

    // stage 25: natural log magnitude, final ratios
    always_comb begin
        logic [esf_pkg::LOG_W-1:0] l, d;
        logic [61:0]               p;
        pipe_next[NP-2] = pipe_reg[NP-3];
        for (int n = 0; n < 3; n++) begin
            l = {pipe_reg[NP-3].msb[n], pipe_reg[NP-3].frac[n]};
            pipe_next[NP-2].neg[n] = (l < LOG_BASE);
            d = pipe_next[NP-2].neg[n] ? LOG_BASE - l : l - LOG_BASE;
            p = 62'(d) * 62'(esf_pkg::LN2_Q32) + (62'(1) << 31);
            pipe_next[NP-2].lnmag[n] = p[61:32];
        end
        for (int r = 0; r < 4; r++) begin
            if (pipe_reg[NP-3].degen) begin
                pipe_next[NP-2].ratio[r] = '0;
            end else if (pipe_reg[NP-3].clamp[r]) begin
                pipe_next[NP-2].ratio[r] = RATIO_ONE;
            end else begin
                pipe_next[NP-2].ratio[r] = {1'b0, pipe_reg[NP-3].quo[r]};
            end
        end
    end

    // stage 26: lambda * ln(lambda), rounded to 16 fraction bits
    always_comb begin
        logic [62:0]                 pr, ts;
        logic [esf_pkg::TERM_W-1:0]  t;
        pipe_next[NP-1] = pipe_reg[NP-2];
        for (int n = 0; n < 3; n++) begin
            pr = 63'(pipe_reg[NP-2].lam[n]) * 63'(pipe_reg[NP-2].lnmag[n]) + T_RND;
            ts = pr >> (EIGEN_FRAC_BITS + 8);
            t  = esf_pkg::TERM_W'(ts);
            if (pipe_reg[NP-2].zero[n]) begin
                pipe_next[NP-1].term[n] = '0;
            end else begin
                pipe_next[NP-1].term[n] = pipe_reg[NP-2].neg[n] ? -t : t;
            end
        end
    end

    // output stage: entropy sum and saturation, curvature limit
    always_comb begin
        logic signed [esf_pkg::ESUM_W-1:0] es;
        logic signed [esf_pkg::ENT_W-1:0]  ent;
        es = -( esf_pkg::ESUM_W'($signed(pipe_reg[NP-1].term[0]))
              + esf_pkg::ESUM_W'($signed(pipe_reg[NP-1].term[1]))
              + esf_pkg::ESUM_W'($signed(pipe_reg[NP-1].term[2])) );
        if (es > esf_pkg::ENT_MAX) begin
            ent = esf_pkg::ENT_W'(esf_pkg::ENT_MAX);
        end else if (es < esf_pkg::ENT_MIN) begin
            ent = esf_pkg::ENT_W'(esf_pkg::ENT_MIN);
        end else begin
            ent = es[esf_pkg::ENT_W-1:0];
        end
        out_data_next = TDATA_W'({ent, pipe_reg[NP-1].ratio[3], pipe_reg[NP-1].ratio[2],
                                  pipe_reg[NP-1].ratio[1], pipe_reg[NP-1].ratio[0]});
        out_user_next = '0;
        out_user_next[esf_pkg::USER_DEGEN] = pipe_reg[NP-1].degen;
        out_user_next[esf_pkg::USER_ORDER] = pipe_reg[NP-1].order;
        out_user_next[esf_pkg::USER_CURV]  = (pipe_reg[NP-1].ratio[3] > max_curv_reg);
    end

    // pipe registers: valid bits cleared on reset, payload held when stalled
    for (genvar i = 0; i < NP; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en[i]) begin
                valid_reg[i] <= (i == 0) ? s_axis_tvalid : valid_reg[(i == 0) ? 0 : i-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en[i]) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en[NP]) begin
            out_valid_reg <= valid_reg[NP-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NP]) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> src/esf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esf_checker
// Port-level checks on the eigenvalue shape feature core.
// ----------------------------------------------------------------------------
module esf_checker #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [((4*(RATIO_FRAC_BITS+1)+esf_pkg::ENT_W+7)/8)*8-1:0] m_axis_tdata,
    input  logic [esf_pkg::USER_W-1:0] m_axis_tuser
);

    localparam int RW = RATIO_FRAC_BITS + 1;
    localparam logic [RATIO_FRAC_BITS:0] RATIO_ONE = RW'(1) << RATIO_FRAC_BITS;

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled transaction changed");

    // degenerate patch gives zero ratios
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[esf_pkg::USER_DEGEN]
            |-> m_axis_tdata[4*RW-1:0] == '0)
        else $error("degenerate patch with nonzero ratio");

    // ratios never exceed one
    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[RW-1:0] <= RATIO_ONE
                       && m_axis_tdata[2*RW-1:RW] <= RATIO_ONE
                       && m_axis_tdata[3*RW-1:2*RW] <= RATIO_ONE
                       && m_axis_tdata[4*RW-1:3*RW] <= RATIO_ONE)
        else $error("ratio above one");

    // curvature flag needs a nonzero curvature
    a_curv_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[esf_pkg::USER_CURV]
            |-> m_axis_tdata[4*RW-1:3*RW] != '0)
        else $error("curvature flag with zero curvature");

endmodule

bind eigenvalue_shape_features_core esf_checker #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
) u_esf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
